// ----- design/first_fit_block_allocator_top_defines.svh -----
// Assertion macros for the block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
// Implication checked on every edge outside reset.
`define FFA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Command and status codes and fixed sizes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;
  localparam logic [1:0] CMD_STATS   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_NOMEM   = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam int HEAP_BYTES = 1048576;

  localparam int FIELD_W = 21;
  typedef logic [FIELD_W-1:0] field_t;
endpackage

// ----- design/first_fit_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap manager over an address-ordered block table in on-chip RAM.
// ----------------------------------------------------------------------------
// Each transfer is handled on its own. The block table sits in one RAM with a
// registered read, and every command walks it one entry per cycle from
// entry 0. A full walk reads every entry of the table, and a search stops at
// the first matching entry. An evaluation step (S_EVAL) follows, then a step
// (S_DONE) that posts the result, and only then is the next transfer taken.
// After evaluation, a free passes through S_POP and S_POPW to pop the block
// or mark it free, and a reallocate that must move walks the table twice
// and, once the new block is allocated, frees the old block. Stats always
// walks the whole table. The result waits in an output register until it is
// taken; the next transfer is accepted meanwhile, and its evaluation waits
// until that register is free.
module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS   = 256,
  parameter int HEADER_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [20:0] size,
  input  logic [20:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [20:0] result_address,
  output logic        moved,
  output logic [20:0] copy_length,
  output logic [20:0] total_heap_bytes,
  output logic [20:0] free_bytes,
  output logic [20:0] used_capacity_bytes,
  output logic [20:0] used_requested_bytes
);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = 20 + 21 + 21 + 1;
  localparam logic [21:0] HEAP_LIM = 22'(ffba_pkg::HEAP_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_POPW = 3'd5;

  logic [EW-1:0] ram [MAX_BLOCKS];
  logic [EW-1:0] rd;
  logic [IW-1:0] raddr;
  logic [IW-1:0] ra;
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    rd <= ram[ra];
  end

  logic [2:0]    state;
  logic [CW-1:0] block_count;
  logic [20:0]   break_offset;
  logic [20:0]   heap_limit;
  logic [1:0]    cmd;
  logic [20:0]   req_size, req_addr;
  logic          phase;       // 0 first pass, 1 allocate pass of a move
  logic [CW-1:0] k;           // entry being read this cycle
  logic [CW-1:0] kd;          // entry whose data is in rd
  logic          rd_ok;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [20:0]   hit_cap, hit_start;
  logic [20:0]   old_cap;
  logic [20:0]   s_tot, s_fr, s_uc, s_ur;
  logic          ov;

  assign ra = (state == S_SCAN) ? k[IW-1:0] : raddr;

  logic [19:0] e_start;
  logic [20:0] e_cap, e_req;
  logic        e_free;
  assign {e_start, e_cap, e_req, e_free} = rd;

  logic [20:0] payload;
  assign payload = 21'(e_start) + 21'(HEADER_BYTES);

  logic alloc_mode;
  assign alloc_mode = (cmd == ffba_pkg::CMD_ALLOC) || phase ||
                      (cmd == ffba_pkg::CMD_REALLOC &&
                       (req_addr == '0 || req_size == '0));

  logic match;
  always_comb begin
    if (alloc_mode) begin
      match = e_free && e_cap >= req_size;
    end else begin
      match = !e_free && {1'b0, payload} == 22'(req_addr);
    end
  end

  logic [22:0] nb;
  logic [21:0] lim;
  assign nb  = 23'(break_offset) + 23'(HEADER_BYTES) + 23'(req_size);
  assign lim = (22'(heap_limit) > HEAP_LIM) ? HEAP_LIM : 22'(heap_limit);

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      block_count <= '0;
      break_offset <= '0;
      heap_limit <= 21'd1048576;
      ov <= 1'b0;
      we <= 1'b0;
    end else begin
      we <= 1'b0;
      if (cfg_we) begin
        heap_limit <= cfg_wdata;
      end
      if (ov && !out_stall) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd <= command;
            req_size <= size;
            req_addr <= address;
            phase <= 1'b0;
            hit <= 1'b0;
            k <= '0;
            rd_ok <= 1'b0;
            s_tot <= '0; s_fr <= '0; s_uc <= '0; s_ur <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          kd <= k;
          rd_ok <= (k < block_count);
          if (k < block_count) begin
            k <= k + 1'b1;
          end
          if (rd_ok) begin
            if (cmd == ffba_pkg::CMD_STATS) begin
              s_tot <= s_tot + e_cap;
              if (e_free) begin
                s_fr <= s_fr + e_cap;
              end else begin
                s_uc <= s_uc + e_cap;
                s_ur <= s_ur + e_req;
              end
            end else if (match && !hit) begin
              hit <= 1'b1;
              hit_idx <= kd[IW-1:0];
              hit_cap <= e_cap;
              hit_start <= 21'(e_start);
            end
          end
          if (!rd_ok && k >= block_count) begin
            state <= S_EVAL;
          end
          if (cmd != ffba_pkg::CMD_STATS && rd_ok && match && !hit) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!ov || !out_stall) begin
            status <= ffba_pkg::ST_OK;
            result_address <= '0;
            moved <= 1'b0;
            copy_length <= '0;
            total_heap_bytes <= '0;
            free_bytes <= '0;
            used_capacity_bytes <= '0;
            used_requested_bytes <= '0;
            state <= S_DONE;
            if (cmd == ffba_pkg::CMD_STATS) begin
              total_heap_bytes <= s_tot;
              free_bytes <= s_fr;
              used_capacity_bytes <= s_uc;
              used_requested_bytes <= s_ur;
            end else if (alloc_mode) begin
              if (req_size == '0) begin
                status <= ffba_pkg::ST_NULL;
              end else if (hit) begin
                we <= 1'b1;
                waddr <= hit_idx;
                wdata <= {hit_start[19:0], hit_cap, req_size, 1'b0};
                result_address <= hit_start + 21'(HEADER_BYTES);
              end else if (nb > 23'(lim) || block_count >= CW'(MAX_BLOCKS)) begin
                status <= ffba_pkg::ST_NOMEM;
              end else begin
                we <= 1'b1;
                waddr <= block_count[IW-1:0];
                wdata <= {break_offset[19:0], req_size, req_size, 1'b0};
                block_count <= block_count + 1'b1;
                break_offset <= nb[20:0];
                result_address <= break_offset + 21'(HEADER_BYTES);
              end
              if (phase && req_size != '0 &&
                  (hit || !(nb > 23'(lim) || block_count >= CW'(MAX_BLOCKS)))) begin
                moved <= 1'b1;
                copy_length <= old_cap;
                state <= S_POP;
              end
            end else if (cmd == ffba_pkg::CMD_FREE && req_addr == '0) begin
              status <= ffba_pkg::ST_NULL;
            end else if (!hit) begin
              status <= ffba_pkg::ST_UNKNOWN;
            end else if (cmd == ffba_pkg::CMD_REALLOC && hit_cap >= req_size) begin
              we <= 1'b1;
              waddr <= hit_idx;
              wdata <= {hit_start[19:0], hit_cap, req_size, 1'b0};
              result_address <= req_addr;
            end else if (cmd == ffba_pkg::CMD_REALLOC) begin
              phase <= 1'b1;
              hit <= 1'b0;
              old_cap <= hit_cap;
              waddr <= hit_idx;
              hit_start <= hit_start;
              raddr <= hit_idx;
              k <= '0;
              rd_ok <= 1'b0;
              kd <= '0;
              hit_cap <= hit_cap;
              state <= S_SCAN;
            end else begin
              raddr <= hit_idx;
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          // Free of the entry in raddr: either pop it or mark it free.
          state <= S_POPW;
        end
        S_POPW: begin
          if ((CW+1)'(raddr) + (CW+1)'(1) == (CW+1)'(block_count)) begin
            block_count <= block_count - 1'b1;
            break_offset <= 21'(e_start);
          end else begin
            we <= 1'b1;
            waddr <= raddr;
            wdata <= {e_start, e_cap, e_req, 1'b1};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!ov) begin
            ov <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov;

  `include "first_fit_block_allocator_top_defines.svh"

  `FFA_ASSERT_IMPL(a_stall_busy, state != S_IDLE, in_stall, "input taken while busy")
  `FFA_ASSERT_IMPL(a_count_range, 1'b1, block_count <= CW'(MAX_BLOCKS), "block count overflow")
  `FFA_ASSERT_NEXT(a_out_hold, ov && out_stall, ov && $stable(status), "result dropped")
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocator testbench
// Drives allocate, free, reallocate and stats requests into the first-fit
// allocator and checks every reply, field by field, against a heap model kept
// in the bench. A short table of directed requests runs first, then random
// phases under several heap limits and idling patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int HDR       = 32;
  localparam int NBLK      = 256;
  localparam int HEAP      = 1048576;
  localparam int SETTLE    = 600;
  localparam int DOG_LIMIT = 20000;
  localparam int HOLD_LEN  = 3000;

  typedef struct packed {
    logic [1:0]  status;
    logic [20:0] result_address;
    logic        moved;
    logic [20:0] copy_length;
    logic [20:0] total_heap_bytes;
    logic [20:0] free_bytes;
    logic [20:0] used_capacity_bytes;
    logic [20:0] used_requested_bytes;
  } heap_reply_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [20:0] sz;
    logic [20:0] addr;
    logic        typed;
    logic [1:0]  st;
    logic [20:0] ra;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [20:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = ffba_pkg::CMD_STATS;
  logic [20:0] size = '0;
  logic [20:0] address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [20:0] result_address;
  logic        moved;
  logic [20:0] copy_length;
  logic [20:0] total_heap_bytes;
  logic [20:0] free_bytes;
  logic [20:0] used_capacity_bytes;
  logic [20:0] used_requested_bytes;

  first_fit_block_allocator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .size(size),
    .address(address), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_address(result_address), .moved(moved),
    .copy_length(copy_length), .total_heap_bytes(total_heap_bytes),
    .free_bytes(free_bytes), .used_capacity_bytes(used_capacity_bytes),
    .used_requested_bytes(used_requested_bytes)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Heap model.
  logic [19:0] blk_start [NBLK];
  logic [20:0] blk_cap [NBLK];
  logic [20:0] blk_req [NBLK];
  bit          blk_free [NBLK];
  int          blk_n = 0;
  longint      brk = 0;
  logic [20:0] heap_lim = 21'd1048576;

  heap_reply_t pending_q[$];
  int errors = 0;
  int n_replies = 0;
  int n_moves = 0;
  int n_status [4] = '{0, 0, 0, 0};
  int send_pct = 0;
  int recv_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic int find_live(logic [20:0] a);
    for (int k = 0; k < blk_n; k++) begin
      if (!blk_free[k] && longint'(blk_start[k]) + HDR == longint'(a)) return k;
    end
    return -1;
  endfunction

  function automatic logic [1:0] grab_block(logic [20:0] sz, output logic [20:0] a);
    longint nb;
    longint lim;
    a = '0;
    if (sz == 0) return ffba_pkg::ST_NULL;
    for (int k = 0; k < blk_n; k++) begin
      if (blk_free[k] && blk_cap[k] >= sz) begin
        blk_free[k] = 1'b0;
        blk_req[k] = sz;
        a = 21'(longint'(blk_start[k]) + HDR);
        return ffba_pkg::ST_OK;
      end
    end
    lim = (longint'(heap_lim) > HEAP) ? HEAP : longint'(heap_lim);
    nb = brk + HDR + longint'(sz);
    if (nb > lim || blk_n >= NBLK) return ffba_pkg::ST_NOMEM;
    blk_start[blk_n] = 20'(brk);
    blk_cap[blk_n] = sz;
    blk_req[blk_n] = sz;
    blk_free[blk_n] = 1'b0;
    a = 21'(brk + HDR);
    blk_n++;
    brk = nb;
    return ffba_pkg::ST_OK;
  endfunction

  function automatic void release_block(int k);
    if (k + 1 == blk_n) begin
      blk_n = k;
      brk = blk_start[k];
    end else begin
      blk_free[k] = 1'b1;
    end
  endfunction

  function automatic heap_reply_t predict_reply(logic [1:0] cmd, logic [20:0] sz,
                                                logic [20:0] addr);
    heap_reply_t r;
    logic [20:0] a;
    logic [20:0] oldcap;
    int idx;
    longint tot, fr, uc, ur;
    r = '0;
    tot = 0; fr = 0; uc = 0; ur = 0;
    case (cmd)
      ffba_pkg::CMD_ALLOC: begin
        r.status = grab_block(sz, a);
        r.result_address = a;
      end
      ffba_pkg::CMD_FREE: begin
        if (addr == 0) begin
          r.status = ffba_pkg::ST_NULL;
        end else begin
          idx = find_live(addr);
          if (idx < 0) r.status = ffba_pkg::ST_UNKNOWN;
          else release_block(idx);
        end
      end
      ffba_pkg::CMD_REALLOC: begin
        if (addr == 0 || sz == 0) begin
          r.status = grab_block(sz, a);
          r.result_address = a;
        end else begin
          idx = find_live(addr);
          if (idx < 0) begin
            r.status = ffba_pkg::ST_UNKNOWN;
          end else if (blk_cap[idx] >= sz) begin
            blk_req[idx] = sz;
            r.result_address = addr;
          end else begin
            oldcap = blk_cap[idx];
            r.status = grab_block(sz, a);
            if (r.status == ffba_pkg::ST_OK) begin
              r.result_address = a;
              r.moved = 1'b1;
              r.copy_length = oldcap;
              release_block(idx);
            end
          end
        end
      end
      default: begin
        for (int k = 0; k < blk_n; k++) begin
          tot += blk_cap[k];
          if (blk_free[k]) fr += blk_cap[k];
          else begin
            uc += blk_cap[k];
            ur += blk_req[k];
          end
        end
        r.total_heap_bytes = 21'(tot);
        r.free_bytes = 21'(fr);
        r.used_capacity_bytes = 21'(uc);
        r.used_requested_bytes = 21'(ur);
      end
    endcase
    return r;
  endfunction

  function automatic logic [20:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 88) return 21'($urandom_range(1, 64));
    if (r < 97) return 21'($urandom_range(65, 8192));
    return 21'($urandom());
  endfunction

  function automatic logic [20:0] live_address();
    int k;
    if (blk_n == 0) return 21'($urandom_range(1, 4096));
    for (int t = 0; t < 8; t++) begin
      k = $urandom_range(0, blk_n - 1);
      if (!blk_free[k]) return 21'(longint'(blk_start[k]) + HDR);
    end
    return 21'(longint'(blk_start[k]) + HDR);
  endfunction

  task automatic offer(logic [1:0] cmd, logic [20:0] sz, logic [20:0] addr,
                       logic typed, logic [1:0] st, logic [20:0] ra);
    heap_reply_t e;
    if (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    size <= sz;
    address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = predict_reply(cmd, sz, addr);
    if (typed) begin
      e.status = st;
      e.result_address = ra;
    end
    pending_q.push_back(e);
  endtask

  task automatic random_item(int alloc_pct);
    int r;
    logic [1:0] cmd;
    logic [20:0] sz;
    logic [20:0] addr;
    r = $urandom_range(0, 99);
    sz = rand_size();
    addr = live_address();
    if (r < 5) begin
      cmd = 2'($urandom());
      sz = 21'($urandom());
      addr = 21'($urandom());
    end else if (r < 5 + alloc_pct) begin
      cmd = ffba_pkg::CMD_ALLOC;
    end else if (r < 50 + alloc_pct / 2) begin
      cmd = ffba_pkg::CMD_FREE;
    end else if (r < 88) begin
      cmd = ffba_pkg::CMD_REALLOC;
      if ($urandom_range(0, 9) == 0) addr = '0;
    end else if (r < 94) begin
      cmd = ffba_pkg::CMD_STATS;
    end else begin
      cmd = ($urandom_range(0, 1) == 0) ? ffba_pkg::CMD_FREE : ffba_pkg::CMD_REALLOC;
      addr = 21'($urandom_range(1, 70000));
    end
    offer(cmd, sz, addr, 1'b0, ffba_pkg::ST_OK, '0);
  endtask

  task automatic drain_and_set_limit(logic [20:0] lim);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    heap_lim = lim;
  endtask

  task automatic check_field(string name, logic [20:0] e, logic [20:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  heap_reply_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          $display("%0t: reply with none expected, status %0d address %0d",
                   $time, status, result_address);
          errors++;
        end else begin
          want = pending_q.pop_front();
          check_field("status", 21'(want.status), 21'(status));
          check_field("result_address", want.result_address, result_address);
          check_field("moved", 21'(want.moved), 21'(moved));
          check_field("copy_length", want.copy_length, copy_length);
          check_field("total_heap_bytes", want.total_heap_bytes, total_heap_bytes);
          check_field("free_bytes", want.free_bytes, free_bytes);
          check_field("used_capacity_bytes", want.used_capacity_bytes,
                      used_capacity_bytes);
          check_field("used_requested_bytes", want.used_requested_bytes,
                      used_requested_bytes);
          n_replies++;
          n_status[want.status]++;
          if (want.moved) n_moves++;
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_LEN;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (recv_pct > 0) && ($urandom_range(0, 99) < recv_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= DOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("tb failed");
      $finish;
    end
  end

  stim_row_t dir_tab [20] = '{
    '{ffba_pkg::CMD_STATS,   21'd0,      21'd0,      1'b1, ffba_pkg::ST_OK,      21'd0},
    '{ffba_pkg::CMD_ALLOC,   21'd0,      21'd0,      1'b1, ffba_pkg::ST_NULL,    21'd0},
    '{ffba_pkg::CMD_ALLOC,   21'd16,     21'd0,      1'b1, ffba_pkg::ST_OK,      21'd32},
    '{ffba_pkg::CMD_ALLOC,   21'd1048576, 21'd0,     1'b1, ffba_pkg::ST_NOMEM,   21'd0},
    '{ffba_pkg::CMD_ALLOC,   21'h1FFFFF, 21'd0,      1'b1, ffba_pkg::ST_NOMEM,   21'd0},
    '{ffba_pkg::CMD_FREE,    21'd0,      21'd0,      1'b1, ffba_pkg::ST_NULL,    21'd0},
    '{ffba_pkg::CMD_FREE,    21'd0,      21'd7,      1'b1, ffba_pkg::ST_UNKNOWN, 21'd0},
    '{ffba_pkg::CMD_FREE,    21'h1FFFFF, 21'h1FFFFF, 1'b1, ffba_pkg::ST_UNKNOWN, 21'd0},
    '{ffba_pkg::CMD_ALLOC,   21'd40,     21'd0,      1'b1, ffba_pkg::ST_OK,      21'd80},
    '{ffba_pkg::CMD_REALLOC, 21'd8,      21'd32,     1'b1, ffba_pkg::ST_OK,      21'd32},
    '{ffba_pkg::CMD_REALLOC, 21'd100,    21'd32,     1'b0, ffba_pkg::ST_OK,      21'd0},
    '{ffba_pkg::CMD_REALLOC, 21'd10,     21'd0,      1'b0, ffba_pkg::ST_OK,      21'd0},
    '{ffba_pkg::CMD_REALLOC, 21'd0,      21'd80,     1'b1, ffba_pkg::ST_NULL,    21'd0},
    '{ffba_pkg::CMD_REALLOC, 21'd5,      21'd999,    1'b1, ffba_pkg::ST_UNKNOWN, 21'd0},
    '{ffba_pkg::CMD_STATS,   21'h1FFFFF, 21'h1FFFFF, 1'b0, ffba_pkg::ST_OK,      21'd0},
    '{ffba_pkg::CMD_REALLOC, 21'h1FFFFF, 21'd80,     1'b1, ffba_pkg::ST_NOMEM,   21'd0},
    '{ffba_pkg::CMD_FREE,    21'd0,      21'd152,    1'b0, ffba_pkg::ST_OK,      21'd0},
    '{ffba_pkg::CMD_FREE,    21'd0,      21'd80,     1'b0, ffba_pkg::ST_OK,      21'd0},
    '{ffba_pkg::CMD_FREE,    21'd0,      21'd32,     1'b0, ffba_pkg::ST_OK,      21'd0},
    '{ffba_pkg::CMD_STATS,   21'd0,      21'd0,      1'b0, ffba_pkg::ST_OK,      21'd0}
  };

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_pct = 31;
    recv_pct = 76;
    foreach (dir_tab[i]) begin
      offer(dir_tab[i].cmd, dir_tab[i].sz, dir_tab[i].addr,
            dir_tab[i].typed, dir_tab[i].st, dir_tab[i].ra);
    end
    drain_and_set_limit(21'd1048576);
    repeat (400) random_item(40);
    drain_and_set_limit(21'd0);
    repeat (100) random_item(40);
    send_pct = 76;
    recv_pct = 31;
    drain_and_set_limit(21'd3000);
    repeat (300) random_item(40);
    send_pct = 0;
    recv_pct = 0;
    drain_and_set_limit(21'h1FFFFF);
    for (int i = 0; i < 500; i++) begin
      if (i == 100) hold_token <= hold_token + 1;
      random_item(70);
    end
    drain_and_set_limit(21'd20000);
    repeat (530) random_item(40);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Checked %0d replies: %0d ok, %0d null, %0d out of memory, %0d unknown.",
             n_replies, n_status[ffba_pkg::ST_OK], n_status[ffba_pkg::ST_NULL],
             n_status[ffba_pkg::ST_NOMEM], n_status[ffba_pkg::ST_UNKNOWN]);
    $display("Reallocate moved %0d blocks; heap limits from 0 to full width were used.",
             n_moves);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
